/* rtl/tamr_pkg.sv */
// Shared types, constants and helpers of the tensor axis min-reduce block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tamr_pkg;

    // Sample format and sizes.
    localparam int SW         = 16;
    localparam int MAG_W      = 2 * SW;
    localparam int MAX_STRIDE = 4096;
    localparam int MAX_DIM    = 4096;
    localparam int SIZE_W     = 13;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int AW         = $clog2(MAX_STRIDE);
    localparam int IDX_W      = 3;
    localparam int AXIS_W     = 2;
    localparam int NDIM       = 4;

    // Queue between front and back, and the result queue.
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = Q_AW + 1;
    localparam int R_DEPTH    = 4;
    localparam int R_AW       = $clog2(R_DEPTH);
    localparam int R_CNT_W    = R_AW + 1;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_SIZE_ROWS    = 3'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_COLS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_SIZE_SLICES  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIZE_HYPER   = 3'd3;
    localparam logic [IDX_W-1:0] REG_REDUCE_AXIS  = 3'd4;
    localparam logic [IDX_W-1:0] REG_COLUMN_MAJOR = 3'd5;
    localparam logic [IDX_W-1:0] REG_COMPLEX_MODE = 3'd6;

    typedef struct packed {
        logic signed [SW-1:0] sample_re;
        logic signed [SW-1:0] sample_im;
    } t_sample;

    typedef struct packed {
        logic signed [SW-1:0] min_re;
        logic signed [SW-1:0] min_im;
        logic                 last_of_tensor;
        logic                 stride_error;
    } t_result;

    // One classified item on its way to the back end.
    typedef struct packed {
        logic [AW-1:0]        addr;
        logic                 first;
        logic                 emit;
        logic                 last;
        logic                 err;
        logic                 cplx;
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic [MAG_W-1:0]     mag;
    } t_job;

    // One partial-minimum entry.
    typedef struct packed {
        logic [MAG_W-1:0]     mag;
        logic signed [SW-1:0] im;
        logic signed [SW-1:0] re;
    } t_entry;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_qstat;

    // Zero acts as one, anything above the largest extent is clamped.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_DIM)) begin
            res = SIZE_W'(MAX_DIM);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/tamr_front.sv */
// Front end: configuration registers, sample intake, squaring and position tracking.
// Depends on tamr_pkg. Feeds classified items into tamr_queue.
`default_nettype none

module tamr_front
    import tamr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [SIZE_W-1:0] i_cfg_data,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire t_sample           i_item,
    input  wire t_qstat            i_q_stat,
    output logic                   o_q_push,
    output t_job                   o_q_job
);

    logic [SIZE_W-1:0] r_size [NDIM];
    logic [AXIS_W-1:0] r_axis;
    logic              r_colmaj;
    logic              r_cplx;
    logic              w_cfg_hit;

    logic [SIZE_W-1:0] w_msize [NDIM];
    logic [DIM_W-1:0]  w_mlast [NDIM];
    logic [AXIS_W-1:0] w_p;
    logic [SIZE_W-1:0] w_f0, w_f1, w_f2;
    logic [2*SIZE_W-1:0] w_pa_full;
    logic [SIZE_W-1:0]   w_pa;
    logic [2*SIZE_W-1:0] w_k;
    logic [SIZE_W-1:0]   r_pa;
    logic                r_err;

    logic                 w_accept;
    logic                 r_s1_v;
    t_sample              r_s1;
    logic signed [MAG_W-1:0] w_sq_re, w_sq_im;
    logic                 r_s2_v;
    t_sample              r_s2;
    logic [MAG_W-1:0]     r_s2_sqre, r_s2_sqim;

    logic [DIM_W-1:0] r_coord [NDIM];
    logic [DIM_W-1:0] n_coord [NDIM];
    logic [AW-1:0]    r_b;
    logic [AW-1:0]    n_b;
    logic [NDIM-1:0]  w_last;
    logic             w_fast_last, w_slow_last, w_axis_last;
    logic             w_carry;
    logic [Q_CNT_W-1:0] w_inflight;

    // Configuration registers; any valid index restarts the tensor.
    assign w_cfg_hit = i_cfg_we && (i_cfg_idx <= REG_COMPLEX_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NDIM; j++) begin
                r_size[j] <= SIZE_W'(1);
            end
            r_axis   <= '0;
            r_colmaj <= 1'b1;
            r_cplx   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIZE_ROWS:    r_size[0] <= i_cfg_data;
                REG_SIZE_COLS:    r_size[1] <= i_cfg_data;
                REG_SIZE_SLICES:  r_size[2] <= i_cfg_data;
                REG_SIZE_HYPER:   r_size[3] <= i_cfg_data;
                REG_REDUCE_AXIS:  r_axis    <= i_cfg_data[AXIS_W-1:0];
                REG_COLUMN_MAJOR: r_colmaj  <= i_cfg_data[0];
                REG_COMPLEX_MODE: r_cplx    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Extents in memory order, fastest first; w_p is the reduced axis in that order.
    always_comb begin
        for (int j = 0; j < NDIM; j++) begin
            w_msize[j] = r_colmaj ? eff_size(r_size[j]) : eff_size(r_size[NDIM-1-j]);
            w_mlast[j] = DIM_W'(w_msize[j] - SIZE_W'(1));
        end
    end

    assign w_p  = r_colmaj ? r_axis : ~r_axis;
    assign w_f0 = (w_p != 2'd0) ? w_msize[0] : SIZE_W'(1);
    assign w_f1 = (w_p >= 2'd2) ? w_msize[1] : SIZE_W'(1);
    assign w_f2 = (w_p == 2'd3) ? w_msize[2] : SIZE_W'(1);

    // Stride check in two registered multiply steps; partial product saturates.
    assign w_pa_full = w_f0 * w_f1;
    assign w_pa = (w_pa_full > (2*SIZE_W)'(MAX_STRIDE)) ? SIZE_W'(MAX_STRIDE + 1)
                                                       : w_pa_full[SIZE_W-1:0];
    assign w_k  = r_pa * w_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa  <= SIZE_W'(1);
            r_err <= 1'b0;
        end else begin
            r_pa  <= w_pa;
            r_err <= w_k > (2*SIZE_W)'(MAX_STRIDE);
        end
    end

    // Credit-based full: queue fill plus items still in the two front stages.
    assign w_inflight = i_q_stat.count + Q_CNT_W'(r_s1_v) + Q_CNT_W'(r_s2_v);
    assign o_full     = w_inflight >= Q_CNT_W'(Q_DEPTH);
    assign w_accept   = i_push && !o_full;

    assign w_sq_re = r_s1.sample_re * r_s1.sample_re;
    assign w_sq_im = r_s1.sample_im * r_s1.sample_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= w_accept;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1      <= i_item;
        r_s2      <= r_s1;
        r_s2_sqre <= unsigned'(w_sq_re);
        r_s2_sqim <= unsigned'(w_sq_im);
    end

    // Position tracking: mixed-radix coordinates plus the vector slot within a group.
    always_comb begin
        w_fast_last = 1'b1;
        w_slow_last = 1'b1;
        w_carry     = 1'b1;
        for (int j = 0; j < NDIM; j++) begin
            w_last[j] = (r_coord[j] == w_mlast[j]);
            if (j < int'(w_p)) begin
                w_fast_last = w_fast_last && w_last[j];
            end
            if (j > int'(w_p)) begin
                w_slow_last = w_slow_last && w_last[j];
            end
            n_coord[j] = r_coord[j];
            if (w_carry) begin
                n_coord[j] = w_last[j] ? '0 : r_coord[j] + DIM_W'(1);
            end
            w_carry = w_carry && w_last[j];
        end
        w_axis_last = w_last[w_p];
        n_b         = w_fast_last ? '0 : r_b + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            for (int j = 0; j < NDIM; j++) begin
                r_coord[j] <= '0;
            end
            r_b <= '0;
        end else if (r_s2_v && !r_err) begin
            for (int j = 0; j < NDIM; j++) begin
                r_coord[j] <= n_coord[j];
            end
            r_b <= n_b;
        end
    end

    always_comb begin
        o_q_push      = r_s2_v;
        o_q_job.addr  = r_b;
        o_q_job.first = (r_coord[w_p] == '0);
        o_q_job.emit  = w_axis_last;
        o_q_job.last  = w_fast_last && w_axis_last && w_slow_last;
        o_q_job.err   = r_err;
        o_q_job.cplx  = r_cplx;
        o_q_job.re    = r_s2.sample_re;
        o_q_job.im    = r_cplx ? r_s2.sample_im : '0;
        o_q_job.mag   = r_cplx ? (r_s2_sqre + r_s2_sqim) : '0;
    end

endmodule

`default_nettype wire

/* rtl/tamr_queue.sv */
// Short queue of classified items between front and back end.
// Depends on tamr_pkg.
`default_nettype none

module tamr_queue
    import tamr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output t_qstat    o_stat
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

endmodule

`default_nettype wire

/* rtl/tamr_back.sv */
// Back end: read-compare-write of partial minima and the result queue.
// Depends on tamr_pkg. Pops classified items from tamr_queue.
`default_nettype none

module tamr_back
    import tamr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_qstat i_q_stat,
    input  wire t_job   i_q_job,
    output logic        o_q_pop,
    input  wire logic   i_pop,
    output logic        o_empty,
    output t_result     o_result
);

    t_entry          r_mem [MAX_STRIDE];
    logic            r_b1_v, r_b2_v;
    t_job            r_b1, r_b2;
    t_entry          r_rd;
    logic            r_wr_v;
    logic [AW-1:0]   r_wr_addr;
    t_entry          r_wr_data;

    t_entry          w_old, w_cand, w_new;
    logic            w_take, w_wr_en, w_res_push, w_res_pop;
    t_result         w_res;

    t_result            r_res [R_DEPTH];
    logic [R_AW-1:0]    r_res_wr, r_res_rd;
    logic [R_CNT_W-1:0] r_res_cnt;

    // Pop only with room for everything already in the two back stages.
    assign o_q_pop = !i_q_stat.empty &&
                     ((r_res_cnt + R_CNT_W'(r_b1_v) + R_CNT_W'(r_b2_v)) < R_CNT_W'(R_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_wr_v <= 1'b0;
        end else begin
            r_b1_v <= o_q_pop;
            r_b2_v <= r_b1_v;
            r_wr_v <= r_wr_v || w_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1 <= i_q_job;
        r_b2 <= r_b1;
        if (w_wr_en) begin
            r_wr_addr <= r_b2.addr;
            r_wr_data <= w_new;
        end
    end

    // Partial store: read in B1, written back from B2.
    always_ff @(posedge i_clk) begin
        if (r_b1_v) begin
            r_rd <= r_mem[r_b1.addr];
        end
        if (w_wr_en) begin
            r_mem[r_b2.addr] <= w_new;
        end
    end

    // Latest write bypasses the store read (same slot on back-to-back items).
    always_comb begin
        w_old       = (r_wr_v && (r_wr_addr == r_b2.addr)) ? r_wr_data : r_rd;
        w_cand.mag  = r_b2.mag;
        w_cand.im   = r_b2.im;
        w_cand.re   = r_b2.re;
        w_take      = r_b2.first ||
                      (r_b2.cplx ? (r_b2.mag < w_old.mag) : (r_b2.re < w_old.re));
        w_new       = w_take ? w_cand : w_old;
        w_wr_en     = r_b2_v && !r_b2.err;
        w_res_push  = r_b2_v && (r_b2.err || r_b2.emit);
        if (r_b2.err) begin
            w_res.min_re         = '0;
            w_res.min_im         = '0;
            w_res.last_of_tensor = 1'b0;
            w_res.stride_error   = 1'b1;
        end else begin
            w_res.min_re         = w_new.re;
            w_res.min_im         = w_new.im;
            w_res.last_of_tensor = r_b2.last;
            w_res.stride_error   = 1'b0;
        end
    end

    // Result queue.
    assign o_empty   = (r_res_cnt == '0);
    assign w_res_pop = i_pop && !o_empty;
    assign o_result  = r_res[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr  <= '0;
            r_res_rd  <= '0;
            r_res_cnt <= '0;
        end else begin
            if (w_res_push) begin
                r_res_wr <= r_res_wr + R_AW'(1);
            end
            if (w_res_pop) begin
                r_res_rd <= r_res_rd + R_AW'(1);
            end
            r_res_cnt <= r_res_cnt + R_CNT_W'(w_res_push) - R_CNT_W'(w_res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_res[r_res_wr] <= w_res;
        end
    end

endmodule

`default_nettype wire

/* rtl/tensor_axis_min_reduce.sv */
// Path: front stages S1 and S2, the queue, back stages B1 and B2, then the result queue.
// Throughput: one item per cycle if results drain; set by the partial store doing one read
//   and one write-back per item on separate ports, with a bypass for the same slot.
// Reset: synchronous active low; clears config to defaults, positions and queues.
//   The partial store is not cleared: slot contents are written on each vector's first item.
// Top level of the tensor axis min-reduce block; uses tamr_pkg, tamr_front,
// tamr_queue and tamr_back.
`default_nettype none

module tensor_axis_min_reduce
    import tamr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // config write port, no read-back
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [SIZE_W-1:0] i_cfg_data,
    // item input, queue style
    input  wire logic              push,
    output logic                   full,
    input  wire t_sample           i_item,
    // result output, queue style
    input  wire logic              pop,
    output logic                   empty,
    output t_result                o_result
);

    t_qstat w_q_stat;
    logic   w_q_push, w_q_pop;
    t_job   w_q_in, w_q_out;

    // Front: registers config, squares samples for complex magnitude, tracks the
    // tensor coordinates in memory order and tags each item with its partial slot,
    // first/last-of-vector and end-of-tensor flags. Stride overflow is checked
    // here too; such items bypass the store and come out flagged.
    tamr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .i_q_stat   (w_q_stat),
        .o_q_push   (w_q_push),
        .o_q_job    (w_q_in)
    );

    // Decoupling queue; front and back stall independently.
    tamr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_q_in),
        .i_pop   (w_q_pop),
        .o_job   (w_q_out),
        .o_stat  (w_q_stat)
    );

    // Back: one read-compare-write on the partial store per item without stride error, with a
    // write bypass for consecutive items on the same slot, then the result queue.
    tamr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_q_job  (w_q_out),
        .o_q_pop  (w_q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* rtl/tamr_checker.sv */
// Port-level checks for tensor_axis_min_reduce, attached by bind.
// Depends on tamr_pkg.
`default_nettype none

module tamr_checker
    import tamr_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    push,
    input wire logic    full,
    input wire logic    pop,
    input wire logic    empty,
    input wire t_result o_result
);

    logic [31:0] r_bal;
    logic [31:0] n_bal;

    // items accepted minus results taken
    assign n_bal = r_bal + 32'(push && !full) - 32'(pop && !empty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal <= '0;
        end else begin
            r_bal <= n_bal;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_bal != '0))
        else $error("result shown with no item outstanding");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.stride_error) |->
        (o_result.min_re == '0 && o_result.min_im == '0 && !o_result.last_of_tensor))
        else $error("stride error result carries data");

endmodule

bind tensor_axis_min_reduce tamr_checker u_tamr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for tensor_axis_min_reduce: directed and random items
// through the queue ports, checked against an in-bench min-reduce predictor.
// Depends on tamr_pkg and the tensor_axis_min_reduce RTL only.
`timescale 1ns / 100ps

module tb_top
    import tamr_pkg::*;
;

    localparam logic [IDX_W-1:0] REG_UNUSED  = 3'd7;   // past the register list
    localparam int               RANDOM_ITEMS = 1050;
    localparam int               DRAIN_SLACK  = 16;     // longer than the pipe latency
    localparam int unsigned      CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // Tracks the running minima of the tensor and queues the minimum that each
    // element completes; checks popped results against that queue in order.
    class min_reduce_scoreboard;
        logic [SIZE_W-1:0]    extent_reg [NDIM];
        logic [AXIS_W-1:0]    axis_sel;
        logic                 col_major;
        logic                 cplx_mode;
        logic signed [SW-1:0] best_re  [MAX_STRIDE];
        logic signed [SW-1:0] best_im  [MAX_STRIDE];
        logic [MAG_W-1:0]     best_mag [MAX_STRIDE];
        longint unsigned      lane_pos, axis_step, group_idx;
        t_result              pending_minima [$];
        int                   mismatches, results_seen, error_results, tensor_ends;

        function new();
            for (int i = 0; i < NDIM; i++) extent_reg[i] = SIZE_W'(1);
            axis_sel  = '0;
            col_major = 1'b1;
            cplx_mode = 1'b0;
            rewind();
        endfunction

        function void rewind();
            lane_pos  = 0;
            axis_step = 0;
            group_idx = 0;
        endfunction

        function void apply_register(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
            case (idx)
                REG_SIZE_ROWS:    extent_reg[0] = data;
                REG_SIZE_COLS:    extent_reg[1] = data;
                REG_SIZE_SLICES:  extent_reg[2] = data;
                REG_SIZE_HYPER:   extent_reg[3] = data;
                REG_REDUCE_AXIS:  axis_sel = data[AXIS_W-1:0];
                REG_COLUMN_MAJOR: col_major = data[0];
                REG_COMPLEX_MODE: cplx_mode = data[0];
                default:          return;    // unknown index: no restart either
            endcase
            rewind();
        endfunction

        // stride between vector neighbors, extent of the reduced axis, element count
        function void shape(output longint unsigned stride, output longint unsigned span,
                            output longint unsigned total);
            longint unsigned ext [NDIM];
            for (int i = 0; i < NDIM; i++) begin
                ext[i] = extent_reg[i];
                if (ext[i] == 0) ext[i] = 1;
                else if (ext[i] > MAX_DIM) ext[i] = MAX_DIM;
            end
            span   = ext[axis_sel];
            stride = 1;
            total  = 1;
            for (int i = 0; i < NDIM; i++) begin
                total *= ext[i];
                if (col_major ? (i < int'(axis_sel)) : (i > int'(axis_sel))) stride *= ext[i];
            end
        endfunction

        function void absorb_element(t_sample s);
            longint unsigned  stride, span, total, groups;
            longint           sre, sim;
            logic [MAG_W-1:0] mag;
            int               slot;
            t_result          r;
            shape(stride, span, total);
            r = '0;
            if (stride > MAX_STRIDE) begin
                r.stride_error = 1'b1;
                pending_minima.push_back(r);
                rewind();
                return;
            end
            groups = total / (stride * span);
            if (lane_pos >= stride || axis_step >= span || group_idx >= groups) rewind();

            sre  = s.sample_re;
            sim  = cplx_mode ? longint'(s.sample_im) : 0;
            mag  = cplx_mode ? MAG_W'(sre * sre + sim * sim) : '0;
            slot = int'(lane_pos);
            // first element of a vector seeds the slot; ties keep the earlier one
            if (axis_step == 0 ||
                (cplx_mode ? (mag < best_mag[slot]) : (sre < longint'(best_re[slot])))) begin
                best_re[slot]  = SW'(sre);
                best_im[slot]  = SW'(sim);
                best_mag[slot] = mag;
            end
            if (axis_step == span - 1) begin
                r.min_re         = best_re[slot];
                r.min_im         = cplx_mode ? best_im[slot] : '0;
                r.last_of_tensor = (group_idx == groups - 1) && (lane_pos == stride - 1);
                pending_minima.push_back(r);
            end

            lane_pos++;
            if (lane_pos == stride) begin
                lane_pos = 0;
                axis_step++;
                if (axis_step == span) begin
                    axis_step = 0;
                    group_idx++;
                    if (group_idx == groups) group_idx = 0;
                end
            end
        endfunction

        function void flag(string what, t_result want, t_result got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected re=%0d im=%0d last=%0b err=%0b",
                         $time, what, want.min_re, want.min_im,
                         want.last_of_tensor, want.stride_error,
                         " / got re=%0d im=%0d last=%0b err=%0b",
                         got.min_re, got.min_im, got.last_of_tensor, got.stride_error);
        endfunction

        function void check_minimum(t_result got);
            t_result want;
            results_seen++;
            if (got.stride_error === 1'b1) error_results++;
            if (got.last_of_tensor === 1'b1) tensor_ends++;
            if (pending_minima.size() == 0) begin
                flag("result with none outstanding", '0, got);
                return;
            end
            want = pending_minima.pop_front();
            if (got.min_re !== want.min_re || got.min_im !== want.min_im ||
                got.last_of_tensor !== want.last_of_tensor ||
                got.stride_error !== want.stride_error)
                flag("result mismatch", want, got);
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx  = '0;
    logic [SIZE_W-1:0] i_cfg_data = '0;
    logic              push       = 1'b0;
    t_sample           i_item     = '0;
    logic              pop        = 1'b0;
    logic              full;
    logic              empty;
    t_result           o_result;

    min_reduce_scoreboard sb;
    int                   gap_pct   = 0;    // chance per cycle that the sender holds off
    int                   stall_pct = 0;    // chance per cycle that the receiver stalls
    int                   items_sent  = 0;
    int                   phase_count = 0;
    int unsigned          cycles      = 0;

    tensor_axis_min_reduce DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .pop        (pop),
        .empty      (empty),
        .o_result   (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: pop decided at the falling edge, result taken at the rising edge.
    always @(negedge i_clk) begin
        pop = i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_minimum(o_result);
    end

    // Watchdog: a hung pipe or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tensor_axis_min_reduce verification failed");
            $finish;
        end
    end

    function automatic void set_idling(t_idle_mode m);
        case (m)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 83; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 83; end
            default:       begin gap_pct = 26; stall_pct = 26; end
        endcase
    endfunction

    // Register write; only called with the pipe idle. Entered and left at a falling edge.
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.apply_register(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Offer one item, holding push until the edge that takes it.
    task automatic send_item(logic signed [SW-1:0] re, logic signed [SW-1:0] im);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push             = 1'b1;
        i_item.sample_re = re;
        i_item.sample_im = im;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.absorb_element(i_item);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Wait out every expected result, then the pipe depth for items with no result.
    task automatic settle();
        push = 1'b0;
        while (sb.pending_minima.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    // One random register setting followed by a stream of elements. Extents are
    // mostly tiny so whole tensors finish; a few are zero, clamped or huge.
    task automatic random_phase();
        logic [SIZE_W-1:0] axis_word;
        logic [AXIS_W-1:0] axis;
        logic [SIZE_W-1:0] ext;
        longint unsigned   stride, span, total;
        int                n;
        axis_word = SIZE_W'($urandom);
        axis      = axis_word[AXIS_W-1:0];
        for (int d = 0; d < NDIM; d++) begin
            if (d == int'(axis)) begin
                ext = SIZE_W'($urandom_range(0, 5));
            end else begin
                case ($urandom_range(0, 31))
                    0:       ext = '0;
                    1:       ext = SIZE_W'(MAX_DIM);
                    2:       ext = SIZE_W'($urandom_range(MAX_DIM + 1, (1 << SIZE_W) - 1));
                    3:       ext = SIZE_W'($urandom_range(5, 64));
                    default: ext = SIZE_W'($urandom_range(1, 3));
                endcase
            end
            write_reg(REG_SIZE_ROWS + IDX_W'(d), ext);
        end
        // upper bits of the narrow registers are random and must be dropped
        write_reg(REG_REDUCE_AXIS, axis_word);
        write_reg(REG_COLUMN_MAJOR, SIZE_W'($urandom));
        write_reg(REG_COMPLEX_MODE, SIZE_W'($urandom));
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, SIZE_W'($urandom));

        sb.shape(stride, span, total);
        if (stride > MAX_STRIDE) n = $urandom_range(2, 6);
        else if (total <= 64 && $urandom_range(0, 3) != 0) n = int'(total) * $urandom_range(1, 2);
        else n = $urandom_range(8, 48);

        repeat (n) begin
            // a quarter of the items near zero so ties and equal magnitudes occur
            if ($urandom_range(0, 3) == 0)
                send_item(SW'($urandom_range(0, 4) - 2), SW'($urandom_range(0, 4) - 2));
            else
                send_item(SW'($urandom), SW'($urandom));
        end
        settle();
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset setting: every element is a whole vector and ends the tensor.
        send_item(-32768, 32767);
        send_item(32767, -32768);
        send_item(0, 0);
        send_item(-1, -1);
        settle();

        // Complex, vectors of three; zero extent acts as one. (3,4), (-4,3) and
        // (5,0) share a magnitude, so the first must win.
        write_reg(REG_COMPLEX_MODE, 1);
        write_reg(REG_SIZE_ROWS, 3);
        write_reg(REG_SIZE_COLS, 0);
        send_item(3, 4);
        send_item(-4, 3);
        send_item(5, 0);
        send_item(-32768, -32768);
        send_item(32767, 32767);
        send_item(0, 1);
        // start a vector, then an out-of-range write must not restart it
        send_item(7, 7);
        settle();
        write_reg(REG_UNUSED, SIZE_W'((1 << SIZE_W) - 1));
        send_item(1, 1);
        send_item(2, 2);
        settle();

        // Real, row-major, three interleaved vectors of two; equal reals tie.
        write_reg(REG_COMPLEX_MODE, 0);
        write_reg(REG_COLUMN_MAJOR, 0);
        write_reg(REG_SIZE_ROWS, 2);
        write_reg(REG_SIZE_COLS, 3);
        send_item(5, 1);
        send_item(-3, 2);
        send_item(0, 0);
        send_item(5, 9);
        send_item(-7, 0);
        send_item(-1, 0);
        settle();

        // Oversized extent clamps to 4096; stride 8192 overflows the buffer.
        write_reg(REG_SIZE_COLS, SIZE_W'((1 << SIZE_W) - 1));
        write_reg(REG_SIZE_SLICES, 2);
        send_item(123, -456);
        send_item(-32768, 32767);
        settle();

        // Stride exactly at the buffer size: column-major, reduce the last axis.
        write_reg(REG_COLUMN_MAJOR, 1);
        write_reg(REG_REDUCE_AXIS, 3);
        write_reg(REG_SIZE_ROWS, SIZE_W'(MAX_DIM));
        write_reg(REG_SIZE_COLS, 1);
        write_reg(REG_SIZE_SLICES, 1);
        write_reg(REG_SIZE_HYPER, 0);
        send_item(-5, 5);
        send_item(32767, 0);
        send_item(-32768, 0);
        settle();

        // Random settings, rotating through the idling patterns.
        begin
            int stop_at;
            stop_at = items_sent + RANDOM_ITEMS;
            while (items_sent < stop_at) begin
                set_idling(t_idle_mode'(phase_count % 4));
                random_phase();
                phase_count++;
            end
        end
        set_idling(IDLE_NONE);
        settle();

        $display("Ran %0d items over %0d random settings; %0d results checked,",
                 items_sent, phase_count, sb.results_seen);
        $display("%0d stride errors, %0d tensor ends, %0d mismatches.",
                 sb.error_results, sb.tensor_ends, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_minima.size() == 0) begin
            $display("tensor_axis_min_reduce verification clean");
        end else begin
            $display("tensor_axis_min_reduce verification failed");
        end
        $finish;
    end

endmodule
